@@ hdl/stok_pkg.sv @@
package stok_pkg;

  localparam int LINE_W = 16;

  // token kinds
  localparam logic [4:0] KIND_INT       = 5'd0;
  localparam logic [4:0] KIND_IDENT     = 5'd1;
  localparam logic [4:0] KIND_KEYWORD   = 5'd2;
  localparam logic [4:0] KIND_PLUS      = 5'd3;
  localparam logic [4:0] KIND_MINUS     = 5'd4;
  localparam logic [4:0] KIND_SLASH     = 5'd5;
  localparam logic [4:0] KIND_STAR      = 5'd6;
  localparam logic [4:0] KIND_COLON     = 5'd7;
  localparam logic [4:0] KIND_DCOLON    = 5'd8;
  localparam logic [4:0] KIND_ASSIGN    = 5'd9;
  localparam logic [4:0] KIND_EQUAL     = 5'd10;
  localparam logic [4:0] KIND_SEMI      = 5'd11;
  localparam logic [4:0] KIND_LBRACE    = 5'd12;
  localparam logic [4:0] KIND_RBRACE    = 5'd13;
  localparam logic [4:0] KIND_LPAREN    = 5'd14;
  localparam logic [4:0] KIND_RPAREN    = 5'd15;
  localparam logic [4:0] KIND_COMMA     = 5'd16;
  localparam logic [4:0] KIND_EOF       = 5'd17;
  localparam logic [4:0] KIND_BAD_CHAR  = 5'd18;
  localparam logic [4:0] KIND_BAD_PUNCT = 5'd19;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // keyword lengths: return, ret, int
  localparam logic [2:0] KW_LEN_RETURN = 3'd6;
  localparam logic [2:0] KW_LEN_RET    = 3'd3;
  localparam logic [2:0] KW_LEN_INT    = 3'd3;

  typedef struct packed {
    logic              is_text;
    logic [7:0]        text_byte;
    logic [4:0]        kind;
    logic [LINE_W-1:0] line;
    logic              last;
  } result_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126 && !is_digit(c) && !is_alpha(c);
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2F:   k = KIND_SLASH;
      8'h2A:   k = KIND_STAR;
      8'h3D:   k = KIND_EQUAL;
      8'h3B:   k = KIND_SEMI;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_BAD_PUNCT;
    endcase
    return k;
  endfunction

  // bit 0 return, bit 1 ret, bit 2 int: keyword character at pos equals c
  function automatic logic [2:0] kw_hit(logic [2:0] pos, logic [7:0] c);
    logic [7:0] c_return;
    logic [7:0] c_int;
    logic       v_return;
    logic       v_int;
    v_return = 1'b1;
    v_int    = 1'b1;
    unique case (pos)
      3'd0:    c_return = 8'h72;
      3'd1:    c_return = 8'h65;
      3'd2:    c_return = 8'h74;
      3'd3:    c_return = 8'h75;
      3'd4:    c_return = 8'h72;
      3'd5:    c_return = 8'h6E;
      default: begin
        c_return = 8'h00;
        v_return = 1'b0;
      end
    endcase
    unique case (pos)
      3'd0:    c_int = 8'h69;
      3'd1:    c_int = 8'h6E;
      3'd2:    c_int = 8'h74;
      default: begin
        c_int = 8'h00;
        v_int = 1'b0;
      end
    endcase
    return {v_int && (c_int == c),
            v_return && (pos < KW_LEN_RET) && (c_return == c),
            v_return && (c_return == c)};
  endfunction

endpackage

@@ hdl/source_tokenizer_top.sv @@
// Byte-serial source tokenizer.
// Input channel (in_valid/in_ready): one source byte ch per request, or an
// end-of-input mark (end_of_input = 1, ch ignored) that closes any pending
// token and yields an eof kind.
// Output channel (out_valid/out_ready): one result per request. is_text = 1
// echoes a number or identifier byte in text_byte; otherwise kind carries a
// token kind. line is the current line count; last marks the final result
// caused by one input request. An input request gives zero, one or two results.
// An accepted request writes its results into the result queue at the accepting edge.
// Throughput: one request per cycle while each gives at most one result and
// out_ready is high; two results of one request take the port in turn. Results go
// through a three-entry result queue, and in_ready is high while that queue
// holds at most one result, so input keeps flowing while a result waits.
// When the receiver stalls the queue fills and in_ready drops; nothing is lost.
// Reset (rst, synchronous) empties the queue, returns to idle with line count
// zero and the next byte marked as the start of a line.
module source_tokenizer_top #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_text,
  output logic [7:0]  text_byte,
  output logic [4:0]  kind,
  output logic [15:0] line,
  output logic        last
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2,
    MODE_COLON = 2'd3
  } mode_t;

  localparam int LW = stok_pkg::LINE_W;

  mode_t                mode, mode_next;
  logic [2:0]           kpos, kpos_next;
  logic [2:0]           kalive, kalive_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic                 at_line_start, als_next;

  // idle handling of the current byte
  logic [LINE_BITS-1:0] idle_line;
  logic                 idle_als;
  mode_t                idle_mode;
  logic                 idle_emit;
  logic                 idle_start_ident;
  stok_pkg::result_t    idle_res;

  logic [LINE_BITS+LW-1:0] cur_line_ext;
  logic [LINE_BITS+LW-1:0] idle_line_ext;
  logic [LW-1:0]           cur_line;
  logic [LW-1:0]           idle_line_lo;

  logic                 has_close;
  logic [4:0]           close_kind;
  logic                 has_main;
  stok_pkg::result_t    main_res;
  logic                 use_idle;
  logic [2:0]           trk_alive;
  logic [4:0]           id_kind;

  stok_pkg::result_t    r0, r1;
  logic [1:0]           n_res;

  stok_pkg::result_t    q [3];
  stok_pkg::result_t    q_next [3];
  stok_pkg::result_t    q_shift [3];
  logic [1:0]           cnt, cnt_next, base;
  logic                 push, pop;

  assign cur_line_ext  = {{LW{1'b0}}, line_count};
  assign idle_line_ext = {{LW{1'b0}}, idle_line};
  assign cur_line      = cur_line_ext[LW-1:0];
  assign idle_line_lo  = idle_line_ext[LW-1:0];

  assign id_kind = ((kalive[0] && kpos == stok_pkg::KW_LEN_RETURN) ||
                    (kalive[1] && kpos == stok_pkg::KW_LEN_RET) ||
                    (kalive[2] && kpos == stok_pkg::KW_LEN_INT)) ?
                   stok_pkg::KIND_KEYWORD : stok_pkg::KIND_IDENT;

  assign trk_alive = kalive & stok_pkg::kw_hit(kpos, ch);

  always_comb begin
    idle_line = line_count;
    if (at_line_start && line_count != {LINE_BITS{1'b1}}) begin
      idle_line = line_count + {{(LINE_BITS-1){1'b0}}, 1'b1};
    end
    idle_als         = (ch == stok_pkg::CH_NL);
    idle_mode        = MODE_IDLE;
    idle_emit        = 1'b0;
    idle_start_ident = 1'b0;
    idle_res         = '0;
    idle_res.line    = idle_line_lo;
    priority if (stok_pkg::is_space(ch)) begin
      idle_emit = 1'b0;
    end else if (stok_pkg::is_digit(ch)) begin
      idle_mode          = MODE_NUM;
      idle_emit          = 1'b1;
      idle_res.is_text   = 1'b1;
      idle_res.text_byte = ch;
    end else if (stok_pkg::is_alpha(ch)) begin
      idle_mode          = MODE_IDENT;
      idle_start_ident   = 1'b1;
      idle_emit          = 1'b1;
      idle_res.is_text   = 1'b1;
      idle_res.text_byte = ch;
    end else if (stok_pkg::is_punct(ch)) begin
      if (ch == stok_pkg::CH_COLON) begin
        idle_mode = MODE_COLON;
      end else begin
        idle_emit     = 1'b1;
        idle_res.kind = stok_pkg::punct_kind(ch);
      end
    end else begin
      idle_emit     = 1'b1;
      idle_res.kind = stok_pkg::KIND_BAD_CHAR;
    end
  end

  always_comb begin
    mode_next     = mode;
    kpos_next     = kpos;
    kalive_next   = kalive;
    line_next     = line_count;
    als_next      = at_line_start;
    has_close     = 1'b0;
    close_kind    = stok_pkg::KIND_INT;
    has_main      = 1'b0;
    main_res      = '0;
    main_res.line = cur_line;
    use_idle      = 1'b0;
    if (end_of_input) begin
      has_close     = (mode != MODE_IDLE);
      unique case (mode)
        MODE_NUM:   close_kind = stok_pkg::KIND_INT;
        MODE_IDENT: close_kind = id_kind;
        MODE_COLON: close_kind = stok_pkg::KIND_COLON;
        default:    close_kind = stok_pkg::KIND_INT;
      endcase
      has_main      = 1'b1;
      main_res.kind = stok_pkg::KIND_EOF;
      mode_next     = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_NUM: begin
          if (stok_pkg::is_digit(ch)) begin
            has_main           = 1'b1;
            main_res.is_text   = 1'b1;
            main_res.text_byte = ch;
          end else if (!stok_pkg::is_space(ch)) begin
            has_close  = 1'b1;
            close_kind = stok_pkg::KIND_INT;
            use_idle   = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (stok_pkg::is_alpha(ch) || stok_pkg::is_digit(ch) ||
              ch == stok_pkg::CH_UNDER) begin
            has_main           = 1'b1;
            main_res.is_text   = 1'b1;
            main_res.text_byte = ch;
            kalive_next        = trk_alive;
            kpos_next          = (kpos == 3'd7) ? kpos : kpos + 3'd1;
          end else begin
            has_close  = 1'b1;
            close_kind = id_kind;
            use_idle   = 1'b1;
          end
        end
        MODE_COLON: begin
          mode_next = MODE_IDLE;
          if (ch == stok_pkg::CH_COLON) begin
            has_main      = 1'b1;
            main_res.kind = stok_pkg::KIND_DCOLON;
          end else if (ch == stok_pkg::CH_EQ) begin
            has_main      = 1'b1;
            main_res.kind = stok_pkg::KIND_ASSIGN;
          end else begin
            has_close  = 1'b1;
            close_kind = stok_pkg::KIND_COLON;
            use_idle   = 1'b1;
          end
        end
        default: use_idle = 1'b1;
      endcase
    end
    // put the closing byte back through idle handling
    if (use_idle) begin
      mode_next = idle_mode;
      line_next = idle_line;
      als_next  = idle_als;
      has_main  = idle_emit;
      main_res  = idle_res;
      if (idle_start_ident) begin
        kpos_next   = 3'd1;
        kalive_next = stok_pkg::kw_hit(3'd0, ch);
      end
    end
  end

  always_comb begin
    r0         = '0;
    r0.kind    = close_kind;
    r0.line    = cur_line;
    r1         = main_res;
    if (!has_close) begin
      r0 = main_res;
    end
    n_res   = {1'b0, has_close} + {1'b0, has_main};
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // result queue: entry 0 drives the output port
  assign out_valid = (cnt != 2'd0);
  assign in_ready  = (cnt <= 2'd1);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign base      = cnt - {1'b0, pop};

  always_comb begin
    q_shift[0] = pop ? q[1] : q[0];
    q_shift[1] = pop ? q[2] : q[1];
    q_shift[2] = q[2];
    for (int i = 0; i < 3; i++) begin
      q_next[i] = q_shift[i];
      if (push && n_res != 2'd0 && 2'(i) == base) begin
        q_next[i] = r0;
      end
      if (push && n_res == 2'd2 && 2'(i) == base + 2'd1) begin
        q_next[i] = r1;
      end
    end
    cnt_next = base + (push ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      cnt           <= 2'd0;
      mode          <= MODE_IDLE;
      kpos          <= 3'd0;
      kalive        <= 3'd0;
      line_count    <= '0;
      at_line_start <= 1'b1;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        mode          <= mode_next;
        kpos          <= kpos_next;
        kalive        <= kalive_next;
        line_count    <= line_next;
        at_line_start <= als_next;
      end
    end
  end

  assign is_text   = q[0].is_text;
  assign text_byte = q[0].text_byte;
  assign kind      = q[0].kind;
  assign line      = q[0].line;
  assign last      = q[0].last;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 260;
  localparam int LONG_HOLD = 60;

  typedef enum logic [1:0] {LX_IDLE, LX_NUM, LX_IDENT, LX_COLON} lex_state_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
  } src_item_t;

  localparam logic [47:0] KW_TEXT [3] = '{"return", "ret", "int"};
  localparam logic [2:0]  KW_LENS [3] = '{stok_pkg::KW_LEN_RETURN, stok_pkg::KW_LEN_RET,
                                          stok_pkg::KW_LEN_INT};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_text;
  logic [7:0]  text_byte;
  logic [4:0]  kind;
  logic [15:0] line;
  logic        last;

  source_tokenizer_top dut (.*);

  src_item_t           pending_bytes[$];
  stok_pkg::result_t   expected_tokens[$];
  int                  pace_max = 5;
  int                  mismatch_count = 0;
  int                  tokens_seen = 0;
  int                  quiet_cycles = 0;
  int                  drv_gap;
  int                  rcv_gap;
  logic                drv_offer = 1'b0;
  src_item_t           drv_next;
  stok_pkg::result_t   got_tok;
  stok_pkg::result_t   want_tok;

  // lexer shadow state
  lex_state_t  lx_mode;
  logic [2:0]  kw_pos;
  logic [2:0]  kw_alive;
  logic [stok_pkg::LINE_W-1:0] line_cnt;
  logic        line_start;
  stok_pkg::result_t tok_buf[2];
  int          tok_n;

  string WORDS [10] = '{"return", "ret", "int", "re", "retur", "returns",
                        "in", "int_", "integer", "r"};
  string SEPS = " ;(\n,)";
  string OPS = "+-/*=;{}(),";
  string ODD = "!#$%&'<>?@[]^_`|~.\"\\";

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [4:0] sym_kind(logic [7:0] c);
    case (c)
      "+": return stok_pkg::KIND_PLUS;
      "-": return stok_pkg::KIND_MINUS;
      "/": return stok_pkg::KIND_SLASH;
      "*": return stok_pkg::KIND_STAR;
      "=": return stok_pkg::KIND_EQUAL;
      ";": return stok_pkg::KIND_SEMI;
      "{": return stok_pkg::KIND_LBRACE;
      "}": return stok_pkg::KIND_RBRACE;
      "(": return stok_pkg::KIND_LPAREN;
      ")": return stok_pkg::KIND_RPAREN;
      ",": return stok_pkg::KIND_COMMA;
      default: return stok_pkg::KIND_BAD_PUNCT;
    endcase
  endfunction

  task automatic note_token(bit txt, logic [7:0] b, logic [4:0] k);
    tok_buf[tok_n] = '{txt, txt ? b : 8'd0, txt ? 5'd0 : k, line_cnt, 1'b0};
    tok_n++;
  endtask

  task automatic kw_advance(logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (kw_pos >= KW_LENS[k]) begin
        kw_alive[k] = 1'b0;
      end else if (KW_TEXT[k][8 * (int'(KW_LENS[k]) - 1 - int'(kw_pos)) +: 8] != c) begin
        kw_alive[k] = 1'b0;
      end
    end
    if (kw_pos != 3'd7) kw_pos++;
  endtask

  function automatic logic [4:0] ident_close();
    for (int k = 0; k < 3; k++) begin
      if (kw_alive[k] && kw_pos == KW_LENS[k]) return stok_pkg::KIND_KEYWORD;
    end
    return stok_pkg::KIND_IDENT;
  endfunction

  task automatic lex_idle(logic [7:0] c);
    if (line_start && line_cnt != {stok_pkg::LINE_W{1'b1}}) line_cnt++;
    line_start = 1'b0;
    if (c == stok_pkg::CH_NL) begin
      line_start = 1'b1;
    end else if (!blank(c)) begin
      if (numeral(c)) begin
        lx_mode = LX_NUM;
        note_token(1'b1, c, stok_pkg::KIND_INT);
      end else if (letter(c)) begin
        lx_mode = LX_IDENT;
        kw_pos = 3'd0;
        kw_alive = 3'b111;
        kw_advance(c);
        note_token(1'b1, c, stok_pkg::KIND_INT);
      end else if (c >= 8'd33 && c <= 8'd126) begin
        if (c == stok_pkg::CH_COLON) lx_mode = LX_COLON;
        else note_token(1'b0, 8'd0, sym_kind(c));
      end else begin
        note_token(1'b0, 8'd0, stok_pkg::KIND_BAD_CHAR);
      end
    end
  endtask

  task automatic predict_tokens(logic [7:0] c, logic eoi);
    tok_n = 0;
    if (eoi) begin
      case (lx_mode)
        LX_NUM:   note_token(1'b0, 8'd0, stok_pkg::KIND_INT);
        LX_IDENT: note_token(1'b0, 8'd0, ident_close());
        LX_COLON: note_token(1'b0, 8'd0, stok_pkg::KIND_COLON);
        default: ;
      endcase
      lx_mode = LX_IDLE;
      note_token(1'b0, 8'd0, stok_pkg::KIND_EOF);
    end else begin
      case (lx_mode)
        LX_NUM: begin
          if (numeral(c)) begin
            note_token(1'b1, c, stok_pkg::KIND_INT);
          end else if (!blank(c)) begin
            note_token(1'b0, 8'd0, stok_pkg::KIND_INT);
            lx_mode = LX_IDLE;
            lex_idle(c);
          end
        end
        LX_IDENT: begin
          if (letter(c) || numeral(c) || c == stok_pkg::CH_UNDER) begin
            kw_advance(c);
            note_token(1'b1, c, stok_pkg::KIND_INT);
          end else begin
            note_token(1'b0, 8'd0, ident_close());
            lx_mode = LX_IDLE;
            lex_idle(c);
          end
        end
        LX_COLON: begin
          lx_mode = LX_IDLE;
          if (c == stok_pkg::CH_COLON) begin
            note_token(1'b0, 8'd0, stok_pkg::KIND_DCOLON);
          end else if (c == stok_pkg::CH_EQ) begin
            note_token(1'b0, 8'd0, stok_pkg::KIND_ASSIGN);
          end else begin
            note_token(1'b0, 8'd0, stok_pkg::KIND_COLON);
            lex_idle(c);
          end
        end
        default: lex_idle(c);
      endcase
    end
    if (tok_n > 0) tok_buf[tok_n - 1].last = 1'b1;
    for (int i = 0; i < tok_n; i++) expected_tokens.push_back(tok_buf[i]);
  endtask

  task automatic push_item(logic [7:0] c, logic eoi);
    pending_bytes.push_back('{c, eoi});
  endtask

  task automatic push_byte(logic [7:0] c);
    push_item(c, 1'b0);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 6) == 0) return 8'd32;
    return 8'($urandom_range(9, 13));
  endfunction

  task automatic add_fragment();
    int len;
    case ($urandom_range(0, 11))
      0: begin
        add_text(WORDS[$urandom_range(0, 9)]);
        push_byte(SEPS[$urandom_range(0, SEPS.len() - 1)]);
      end
      1, 2: begin
        push_byte(rand_letter());
        len = $urandom_range(0, 9);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: push_byte(8'($urandom_range(48, 57)));
            1: push_byte(stok_pkg::CH_UNDER);
            default: push_byte(rand_letter());
          endcase
        end
        push_byte(SEPS[$urandom_range(0, SEPS.len() - 1)]);
      end
      3: begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          push_byte(8'($urandom_range(48, 57)));
          if ($urandom_range(0, 3) == 0) push_byte(rand_blank());
        end
      end
      4, 5: push_byte(OPS[$urandom_range(0, OPS.len() - 1)]);
      6: begin
        push_byte(stok_pkg::CH_COLON);
        case ($urandom_range(0, 2))
          0: push_byte(stok_pkg::CH_COLON);
          1: push_byte(stok_pkg::CH_EQ);
          default: add_fragment();
        endcase
      end
      7: push_byte(rand_blank());
      8: push_byte(stok_pkg::CH_NL);
      9: push_byte(8'($urandom_range(0, 255)));
      10: push_byte(ODD[$urandom_range(0, ODD.len() - 1)]);
      default: push_item(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || drv_offer ||
           expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  // request driver and shadow lexer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
      lx_mode = LX_IDLE;
      kw_pos = 3'd0;
      kw_alive = 3'd0;
      line_cnt = '0;
      line_start = 1'b1;
    end else begin
      drv_offer = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_tokens(ch, end_of_input);
        drv_gap = $urandom_range(0, pace_max);
      end
      if (!drv_offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_bytes.size() > 0) begin
          drv_next = pending_bytes.pop_front();
          ch <= drv_next.c;
          end_of_input <= drv_next.eoi;
          drv_offer = 1'b1;
        end
      end
      in_valid <= drv_offer;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_tok = '{is_text, text_byte, kind, line, last};
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got_tok);
          mismatch_count++;
        end else begin
          want_tok = expected_tokens.pop_front();
          check_field("is_text", want_tok.is_text, got_tok.is_text);
          check_field("text_byte", want_tok.text_byte, got_tok.text_byte);
          check_field("kind", want_tok.kind, got_tok.kind);
          check_field("line", want_tok.line, got_tok.line);
          check_field("last", want_tok.last, got_tok.last);
        end
        rcv_gap = $urandom_range(0, pace_max);
        // hold off long enough to back up the result queue
        if (tokens_seen == 250 || tokens_seen == 1000) rcv_gap = LONG_HOLD;
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int goal;
    // keyword, number spanning blanks and a newline, colon pairs, bad bytes, eof flushes
    add_text("ret;7 \n8:=::{:}");
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'hFF);
    add_text("_a");
    push_item(8'hA5, 1'b1);
    push_byte(stok_pkg::CH_COLON);
    push_item(8'h5A, 1'b1);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      pace_max = (p == 1) ? 0 : ((p == 3) ? 2 : 5);
      goal = pending_bytes.size() + PHASE_ITEMS;
      while (pending_bytes.size() < goal) add_fragment();
      wait_drained();
    end

    pace_max = 1;
    repeat (30) add_fragment();
    push_item(8'h00, 1'b1);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
